[rtl/sbfr_pkg.sv]
// sbfr_pkg: shared types and constants of the s.bus frame receiver
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sbfr_pkg;

   // data bytes held between the start byte and the end byte
   localparam int unsigned FRAME_DATA_BYTES = 23;
   localparam int unsigned FRAME_ADDR_W     = $clog2(FRAME_DATA_BYTES);
   localparam int unsigned FLAG_BYTE_IDX    = FRAME_DATA_BYTES - 1;

   // field widths
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned GAP_W      = 16;
   localparam int unsigned INDEX_W    = 5;
   localparam int unsigned VALUE_W    = 12;
   localparam int unsigned ERRCNT_W   = 16;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned RSP_PAD_W  = RSP_DATA_W - INDEX_W - VALUE_W - ERRCNT_W;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // channel unpacking
   localparam int unsigned CHAN_BITS   = 11;
   localparam int unsigned NUM_ANALOG  = 16;
   localparam int unsigned CHAN_IDX_W  = 4;
   localparam int unsigned ACC_W       = CHAN_BITS - 1 + BYTE_W;
   localparam int unsigned ACC_CNT_W   = 5;
   localparam logic [CHAN_IDX_W-1:0] ALT_CHAN = 4'd2;

   localparam logic [VALUE_W-1:0] CENTER_BASE = 12'd1024;
   localparam logic [VALUE_W-1:0] ALT_BASE    = 12'd1696;
   localparam logic [VALUE_W-1:0] DIGITAL_HI  = 12'd800;
   localparam logic [VALUE_W-1:0] DIGITAL_LO  = 12'hCE0;  // -800

   localparam logic [INDEX_W-1:0] DIG0_INDEX = 5'd16;
   localparam logic [INDEX_W-1:0] DIG1_INDEX = 5'd17;

   // flag bits of the last data byte
   localparam int unsigned FLAG_DIG0 = 0;
   localparam int unsigned FLAG_DIG1 = 1;
   localparam int unsigned FLAG_LOST = 2;

   // reset values of the control registers
   localparam logic [GAP_W-1:0]  GAP_TIMEOUT_RST = 16'd3000;
   localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'h0F;
   localparam logic [BYTE_W-1:0] END_MASK_RST    = 8'h00;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GAP_TIMEOUT = 2'd0,
      CSR_START_BYTE  = 2'd1,
      CSR_END_MASK    = 2'd2
   } sbfr_csr_type;

   typedef enum logic [1:0] {
      PH_SYNC = 2'd0,
      PH_DATA = 2'd1,
      PH_END  = 2'd2
   } sbfr_phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAP,
      ST_STEP,
      ST_FLAG,
      ST_ERR,
      ST_LOAD,
      ST_MERGE,
      ST_SUB,
      ST_EMIT,
      ST_DIG0,
      ST_DIG1
   } sbfr_state_type;

endpackage

`default_nettype wire

[rtl/sbfr_frame_mem.sv]
// sbfr_frame_mem: storage for the data bytes of one frame
// one write port, one registered read port; uses sbfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbfr_frame_mem
   import sbfr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    we,
   input  wire logic [FRAME_ADDR_W-1:0] waddr,
   input  wire logic [BYTE_W-1:0]       wdata,
   input  wire logic [FRAME_ADDR_W-1:0] raddr,
   output logic      [BYTE_W-1:0]       rdata_ff
);

   logic [BYTE_W-1:0] mem_ff [FRAME_DATA_BYTES];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

[rtl/sbfr_sub_unit.sv]
// sbfr_sub_unit: shared subtractor with registered result
// serves the byte gap check and the channel centering; uses sbfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbfr_sub_unit
   import sbfr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [TIME_W-1:0] op_a,
   input  wire logic [TIME_W-1:0] op_b,
   output logic      [TIME_W-1:0] diff_ff
);

   logic [TIME_W-1:0] diff_in;

   assign diff_in = op_a - op_b;

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
   end

endmodule

`default_nettype wire

[rtl/sbfr_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// S.BUS frame receiver. Each input word carries one received byte and its free-running
// microsecond timestamp. A gap above gap_timeout_us drops the receiver back to hunting
// for start_byte. After the start byte, 23 data bytes are stored; the following end byte
// must have no bit set that end_mask selects, and at least one data byte must be nonzero.
// A good frame then gives 18 result words (channels 0..15 centered, channel 2 against
// 1696, the others against 1024, then two digital channels as +/-800), or a single error
// word when the frame-lost flag is set. Each ordinary byte goes through accept, gap
// subtract and state update. An accepted end byte that decodes keeps the block busy
// until its last result word is loaded, so an output stall holds it longer. The sequencer
// reads the frame memory one byte at a time and runs every channel through the one shared
// subtractor. The next byte is taken while the last result still waits in the output register.
// depends on sbfr_pkg, sbfr_frame_mem, sbfr_sub_unit

module sbus_frame_receiver_top
   import sbfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   // received bytes
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // rx_byte[7:0], time_us[39:8]
   // decoded results
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // channel_index[4:0], channel_value[16:5],
                                                   // error_count[32:17], zero[39:33]
   output logic                       rsp_tuser,   // status
   output logic                       rsp_tlast
);

   sbfr_state_type state_ff, state_in;
   sbfr_phase_type phase_ff, phase_in;

   logic [GAP_W-1:0]        gap_timeout_ff;
   logic [BYTE_W-1:0]       start_byte_ff;
   logic [BYTE_W-1:0]       end_mask_ff;

   logic [FRAME_ADDR_W-1:0] byte_count_ff, byte_count_in;
   logic                    seen_ff, seen_in;
   logic [TIME_W-1:0]       last_time_ff, last_time_in;
   logic [ERRCNT_W-1:0]     errors_ff, errors_in;

   logic [BYTE_W-1:0]       rx_byte_ff, rx_byte_in;
   logic [TIME_W-1:0]       time_ff, time_in;
   logic [1:0]              flags_ff, flags_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [ACC_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [FRAME_ADDR_W-1:0] ptr_ff, ptr_in;
   logic [CHAN_IDX_W-1:0]   ch_ff, ch_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic [VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [ERRCNT_W-1:0]     rsp_errors_ff, rsp_errors_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_load;
   logic                    out_free;

   logic                    mem_we;
   logic [FRAME_ADDR_W-1:0] mem_raddr;
   logic [BYTE_W-1:0]       mem_rdata;

   logic [TIME_W-1:0]       sub_a, sub_b, sub_diff;
   logic [VALUE_W-1:0]      chan_base;
   logic                    gap_over;
   sbfr_phase_type          phase_eff;

   sbfr_frame_mem u_mem (
      .clock    (clock),
      .we       (mem_we),
      .waddr    (byte_count_ff),
      .wdata    (rx_byte_ff),
      .raddr    (mem_raddr),
      .rdata_ff (mem_rdata)
   );

   sbfr_sub_unit u_sub (
      .clock   (clock),
      .op_a    (sub_a),
      .op_b    (sub_b),
      .diff_ff (sub_diff)
   );

   assign chan_base = (ch_ff == ALT_CHAN) ? ALT_BASE : CENTER_BASE;

   // the subtractor does the gap first, then one channel at a time
   always_comb begin
      if (state_ff == ST_GAP) begin
         sub_a = time_ff;
         sub_b = last_time_ff;
      end else begin
         sub_a = TIME_W'(chan_base);
         sub_b = TIME_W'(acc_ff[CHAN_BITS-1:0]);
      end
   end

   assign gap_over  = sub_diff > TIME_W'(gap_timeout_ff);
   assign phase_eff = gap_over ? PH_SYNC : phase_ff;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      seen_in       = seen_ff;
      last_time_in  = last_time_ff;
      errors_in     = errors_ff;
      rx_byte_in    = rx_byte_ff;
      time_in       = time_ff;
      flags_in      = flags_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      ch_in         = ch_ff;
      mem_we        = 1'b0;
      mem_raddr     = ptr_ff;
      rsp_load      = 1'b0;
      rsp_status_in = 1'b0;
      rsp_index_in  = INDEX_W'(ch_ff);
      rsp_value_in  = sub_diff[VALUE_W-1:0];
      rsp_errors_in = errors_ff;
      rsp_last_in   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rx_byte_in = req_tdata[BYTE_W-1:0];
               time_in    = req_tdata[BYTE_W +: TIME_W];
               state_in   = ST_GAP;
            end
         end
         ST_GAP: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            last_time_in = time_ff;
            state_in     = ST_IDLE;
            case (phase_eff)
               PH_DATA: begin
                  mem_we        = 1'b1;
                  byte_count_in = byte_count_ff + 1'b1;
                  if (byte_count_ff == FRAME_ADDR_W'(FRAME_DATA_BYTES - 1)) begin
                     phase_in = PH_END;
                  end
                  if (rx_byte_ff != '0) begin
                     seen_in = 1'b1;
                  end
               end
               PH_END: begin
                  phase_in  = PH_SYNC;
                  mem_raddr = FRAME_ADDR_W'(FLAG_BYTE_IDX);
                  if (((rx_byte_ff & end_mask_ff) == '0) && seen_ff) begin
                     state_in = ST_FLAG;
                  end
               end
               default: begin
                  phase_in = PH_SYNC;
                  if (rx_byte_ff == start_byte_ff) begin
                     phase_in      = PH_DATA;
                     byte_count_in = '0;
                     seen_in       = 1'b0;
                  end
               end
            endcase
         end
         ST_FLAG: begin
            flags_in = mem_rdata[FLAG_DIG1:FLAG_DIG0];
            acc_in   = '0;
            cnt_in   = '0;
            ptr_in   = '0;
            ch_in    = '0;
            state_in = mem_rdata[FLAG_LOST] ? ST_ERR : ST_LOAD;
         end
         ST_ERR: begin
            if (out_free) begin
               errors_in     = errors_ff + 1'b1;
               rsp_load      = 1'b1;
               rsp_status_in = 1'b1;
               rsp_index_in  = '0;
               rsp_value_in  = '0;
               rsp_errors_in = errors_ff + 1'b1;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_LOAD: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            // append the byte above the bits still waiting
            acc_in   = acc_ff | (ACC_W'(mem_rdata) << cnt_ff);
            cnt_in   = cnt_ff + ACC_CNT_W'(BYTE_W);
            ptr_in   = ptr_ff + 1'b1;
            state_in = (cnt_ff >= ACC_CNT_W'(CHAN_BITS - BYTE_W)) ? ST_SUB : ST_LOAD;
         end
         ST_SUB: begin
            cnt_in   = cnt_ff - ACC_CNT_W'(CHAN_BITS);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // channel bits stay in place until the word is loaded, so the difference holds
            if (out_free) begin
               rsp_load = 1'b1;
               acc_in   = acc_ff >> CHAN_BITS;
               ch_in    = ch_ff + 1'b1;
               if (ch_ff == CHAN_IDX_W'(NUM_ANALOG - 1)) begin
                  state_in = ST_DIG0;
               end else if (cnt_ff >= ACC_CNT_W'(CHAN_BITS)) begin
                  state_in = ST_SUB;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_DIG0: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_index_in = DIG0_INDEX;
               rsp_value_in = flags_ff[FLAG_DIG0] ? DIGITAL_HI : DIGITAL_LO;
               state_in     = ST_DIG1;
            end
         end
         ST_DIG1: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_index_in = DIG1_INDEX;
               rsp_value_in = flags_ff[FLAG_DIG1] ? DIGITAL_HI : DIGITAL_LO;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_SYNC;
         byte_count_ff  <= '0;
         seen_ff        <= 1'b0;
         last_time_ff   <= '0;
         errors_ff      <= '0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         gap_timeout_ff <= GAP_TIMEOUT_RST;
         start_byte_ff  <= START_BYTE_RST;
         end_mask_ff    <= END_MASK_RST;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         seen_ff       <= seen_in;
         last_time_ff  <= last_time_in;
         errors_ff     <= errors_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_GAP_TIMEOUT: gap_timeout_ff <= csr_wdata[GAP_W-1:0];
               CSR_START_BYTE:  start_byte_ff  <= csr_wdata[BYTE_W-1:0];
               CSR_END_MASK:    end_mask_ff    <= csr_wdata[BYTE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rx_byte_ff <= rx_byte_in;
      time_ff    <= time_in;
      flags_ff   <= flags_in;
      acc_ff     <= acc_in;
      ptr_ff     <= ptr_in;
      ch_ff      <= ch_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_errors_ff <= rsp_errors_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_errors_ff, rsp_value_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (byte_count_ff < FRAME_ADDR_W'(FRAME_DATA_BYTES)))
      else $error("byte count past frame end while collecting data");

   a_error_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERR && out_free) |=> (errors_ff == $past(errors_ff) + 1'b1))
      else $error("error counter not bumped on frame-lost result");

   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after last word of frame");

   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= ACC_CNT_W'(ACC_W)))
      else $error("unpack bit count overflows accumulator");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !rsp_load)
      else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

[verif/sbus_frame_receiver_top_test.sv]
// sbus_frame_receiver_top_test: self-checking bench for the s.bus frame receiver
// feeds timestamped bytes, predicts every channel word and checks the rsp stream
// depends on sbfr_pkg and sbus_frame_receiver_top
`timescale 1ns / 1ps

module sbus_frame_receiver_top_test;
   import sbfr_pkg::*;

   localparam int DATA_BYTES    = 23;
   localparam int FRAME_LEN     = DATA_BYTES + 2;
   localparam int NUM_ANALOG_CH = 16;
   localparam int NUM_CHANNELS  = 18;
   localparam int ALT_CHANNEL   = 2;
   localparam int LOST_BIT      = 2;
   localparam logic [11:0] MID_VALUE     = 12'd1024;
   localparam logic [11:0] ALT_MID_VALUE = 12'd1696;
   localparam logic [11:0] DIG_ON        = 12'd800;
   localparam logic [11:0] DIG_OFF       = 12'hCE0;  // -800
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 1200;
   localparam int MAX_SHOWN     = 10;

   typedef struct packed {
      logic        status;
      logic [4:0]  index;
      logic [11:0] value;
      logic [15:0] errcnt;
      logic        last;
   } chan_word_type;

   typedef enum {ROW_FRAME, ROW_REGS} row_kind_type;
   typedef enum {OUT_MODEL, OUT_NONE, OUT_LOST, OUT_FLAT} row_outcome_type;

   typedef struct {
      row_kind_type    kind;
      row_outcome_type outcome;
      logic [31:0]  t0;         // nonzero: jump the byte clock here first
      logic [31:0]  step;
      logic         rand_fill;
      logic [7:0]   fill;
      logic [7:0]   flag;
      logic [7:0]   endb;
      int           break_at;   // byte position that arrives after a timeout gap
      logic [10:0]  raw;        // raw value of every analog channel on flat frames
      logic [15:0]  errcnt;
      logic [15:0]  gap;
      logic [7:0]   start;
      logic [7:0]   mask;
   } dir_row_type;

   localparam int NUM_ROWS = 6;
   // kind, outcome, t0, step, rand_fill, fill, flag, end, break, raw, errors, gap, start, mask
   dir_row_type dir_rows [NUM_ROWS] = '{
      '{ROW_FRAME, OUT_FLAT,  0, 10,    0, 'h00, 'h03, 'h00, -1, 0,    0, 0, 0, 0},
      '{ROW_FRAME, OUT_FLAT,  0, 3000,  0, 'hFF, 'h03, 'h00, -1, 2047, 0, 0, 0, 0},
      '{ROW_FRAME, OUT_LOST,  0, 25,    0, 'h00, 'h04, 'h00, -1, 0,    1, 0, 0, 0},
      '{ROW_FRAME, OUT_NONE,  0, 25,    0, 'h11, 'h02, 'h00, 12, 0,    0, 0, 0, 0},
      '{ROW_REGS,  OUT_NONE,  0, 0,     0, 'h00, 'h00, 'h00, -1, 0,    0, 65535, 'hFF, 'h80},
      '{ROW_FRAME, OUT_MODEL, 'hFFFF_FFF0, 7, 1, 'h00, 'h01, 'h00, -1, 0, 0, 0, 0, 0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   sbfr_csr_type          csr_addr = CSR_GAP_TIMEOUT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   // receiver pacing and long hold-off
   int   send_idle_pct = 25;
   int   recv_idle_pct = 81;
   logic hold_req = 1'b0;
   logic hold_ack = 1'b0;
   int   hold_left = 0;

   // predicted receiver state and register copies
   sbfr_phase_type rx_phase = PH_SYNC;
   logic [4:0]     rx_count = '0;
   logic [7:0]     rx_bytes [DATA_BYTES];
   logic           rx_nonzero = 1'b0;
   logic [31:0]    rx_last_time = '0;
   logic [15:0]    rx_errors = '0;
   logic [15:0]    cfg_gap = 16'd3000;
   logic [7:0]     cfg_start = 8'h0F;
   logic [7:0]     cfg_mask = 8'h00;

   chan_word_type chan_expect_q [$];
   logic        typed_row = 1'b0;
   logic        resync_pending = 1'b0;
   logic [31:0] now_us = '0;
   int          mismatches = 0;

   sbus_frame_receiver_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack   <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic string show(chan_word_type w);
      return $sformatf("status %0d ch %0d value %0d errors %0d last %0d",
                       w.status, w.index, $signed(w.value), w.errcnt, w.last);
   endfunction

   always @(posedge clock) begin
      chan_word_type got;
      chan_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[4:0], rsp_tdata[16:5], rsp_tdata[32:17], rsp_tlast};
         if (chan_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) $display("unexpected word: %s", show(got));
         end else begin
            want = chan_expect_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("word mismatch: expected %s, got %s", show(want), show(got));
            end
         end
      end
   end

   // advances the predicted receiver by one byte and queues the words it causes
   task automatic decode_rx_byte(input logic [7:0] c, input logic [31:0] t);
      logic [DATA_BYTES*8-1:0] bits;
      chan_word_type w;
      int i;
      if (t - rx_last_time > 32'(cfg_gap)) rx_phase = PH_SYNC;
      rx_last_time = t;
      case (rx_phase)
         PH_DATA: begin
            if (rx_count < DATA_BYTES) rx_bytes[rx_count] = c;
            rx_count = rx_count + 5'd1;
            if (rx_count >= DATA_BYTES) rx_phase = PH_END;
            if (c != 8'h00) rx_nonzero = 1'b1;
         end
         PH_END: begin
            rx_phase = PH_SYNC;
            if ((c & cfg_mask) == 8'h00 && rx_nonzero) begin
               if (rx_bytes[DATA_BYTES-1][LOST_BIT]) begin
                  rx_errors = rx_errors + 16'd1;
                  w = '{1'b1, 5'd0, 12'd0, rx_errors, 1'b1};
                  if (!typed_row) chan_expect_q.push_back(w);
               end else begin
                  for (i = 0; i < DATA_BYTES; i++) bits[i*8 +: 8] = rx_bytes[i];
                  for (i = 0; i < NUM_CHANNELS; i++) begin
                     w.status = 1'b0;
                     w.index  = 5'(i);
                     w.errcnt = rx_errors;
                     w.last   = (i == NUM_CHANNELS - 1);
                     if (i < NUM_ANALOG_CH)
                        w.value = (i == ALT_CHANNEL ? ALT_MID_VALUE : MID_VALUE)
                                  - {1'b0, bits[i*11 +: 11]};
                     else
                        w.value = rx_bytes[DATA_BYTES-1][i-NUM_ANALOG_CH] ? DIG_ON : DIG_OFF;
                     if (!typed_row) chan_expect_q.push_back(w);
                  end
               end
            end
         end
         default: begin
            rx_phase = PH_SYNC;
            if (c == cfg_start) begin
               rx_phase   = PH_DATA;
               rx_count   = '0;
               rx_nonzero = 1'b0;
            end
         end
      endcase
   endtask

   // offers one byte stamped with now_us; valid stays high unless the sender idles
   task automatic send_byte(input logic [7:0] c);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now_us, c};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_rx_byte(c, now_us);
   endtask

   // waits for the block to drain and go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (chan_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [15:0] gap, input logic [7:0] start,
                               input logic [7:0] mask);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_GAP_TIMEOUT;
      csr_wdata <= gap;
      @(posedge clock);
      csr_addr  <= CSR_START_BYTE;
      csr_wdata <= {8'h00, start};
      @(posedge clock);
      csr_addr  <= CSR_END_MASK;
      csr_wdata <= {8'h00, mask};
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_gap   = gap;
      cfg_start = start;
      cfg_mask  = mask;
   endtask

   // gap to the next byte; after a broken sequence it forces a resync
   function automatic logic [31:0] pick_step();
      logic [31:0] s;
      s = resync_pending ? 32'(cfg_gap) + 32'd1 : 32'($urandom_range(0, cfg_gap));
      resync_pending = 1'b0;
      return s;
   endfunction

   task automatic send_random_frame(input bit broken, input bit clean, output int sent);
      logic [7:0] fb [FRAME_LEN];
      int cut;
      int brk;
      int k;
      bit zeros;
      zeros = !clean && ($urandom_range(0, 9) == 0);
      fb[0] = cfg_start;
      for (k = 1; k <= DATA_BYTES; k++) fb[k] = zeros ? 8'h00 : 8'($urandom);
      if (!zeros) fb[DATA_BYTES][LOST_BIT] = clean ? 1'b0 : ($urandom_range(0, 3) == 0);
      fb[FRAME_LEN-1] = 8'($urandom);
      if (clean || $urandom_range(0, 4) != 0) fb[FRAME_LEN-1] &= ~cfg_mask;
      cut = FRAME_LEN;
      brk = -1;
      if (broken) begin
         if ($urandom_range(0, 1) != 0) cut = $urandom_range(1, FRAME_LEN - 1);
         else brk = $urandom_range(1, FRAME_LEN - 1);
      end
      for (k = 0; k < cut; k++) begin
         now_us += pick_step();
         if (k == brk) now_us += 32'(cfg_gap) + 32'($urandom_range(1, 100));
         send_byte(fb[k]);
      end
      if (broken) resync_pending = 1'b1;
      sent = cut;
   endtask

   task automatic random_phase(input int send_pct, input int recv_pct, input int budget);
      logic [15:0] g;
      int done_items;
      int n;
      int r;
      settle();
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
      case ($urandom_range(0, 3))
         0: g = 16'($urandom_range(0, 40));
         1: g = 16'hFFFF;
         default: g = 16'($urandom_range(41, 65534));
      endcase
      program_regs(g, 8'($urandom), ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom));
      now_us = $urandom;
      resync_pending = 1'b1;
      done_items = 0;
      while (done_items < budget) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            send_random_frame(1'b0, 1'b0, n);
            done_items += n;
         end else if (r < 85) begin
            send_random_frame(1'b1, 1'b0, n);
            done_items += n;
         end else begin
            // stray bytes between frames, with wide time jumps
            n = $urandom_range(1, 4);
            repeat (n) begin
               now_us += $urandom;
               send_byte(8'($urandom));
            end
            done_items += n;
            resync_pending = 1'b1;
         end
      end
   endtask

   initial begin
      dir_row_type   row;
      chan_word_type w;
      logic [7:0] b;
      int k;
      int ch;
      int n;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_REGS) begin
            settle();
            program_regs(row.gap, row.start, row.mask);
         end else begin
            typed_row = (row.outcome != OUT_MODEL);
            if (row.t0 != 0) now_us = row.t0;
            for (k = 0; k < FRAME_LEN; k++) begin
               if (k == 0) b = cfg_start;
               else if (k == FRAME_LEN - 1) b = row.endb;
               else if (k == FRAME_LEN - 2) b = row.flag;
               else b = row.rand_fill ? 8'($urandom) : row.fill;
               now_us += row.step;
               if (k == row.break_at) now_us += 32'(cfg_gap) + 32'd1;
               send_byte(b);
            end
            case (row.outcome)
               OUT_LOST: chan_expect_q.push_back('{1'b1, 5'd0, 12'd0, row.errcnt, 1'b1});
               OUT_FLAT: begin
                  for (ch = 0; ch < NUM_CHANNELS; ch++) begin
                     w.status = 1'b0;
                     w.index  = 5'(ch);
                     w.errcnt = row.errcnt;
                     w.last   = (ch == NUM_CHANNELS - 1);
                     if (ch < NUM_ANALOG_CH)
                        w.value = (ch == ALT_CHANNEL ? ALT_MID_VALUE : MID_VALUE)
                                  - {1'b0, row.raw};
                     else
                        w.value = row.flag[ch-NUM_ANALOG_CH] ? DIG_ON : DIG_OFF;
                     chan_expect_q.push_back(w);
                  end
               end
               default: ;
            endcase
            typed_row = 1'b0;
         end
      end

      random_phase(25, 81, 20);
      random_phase(81, 25, 20);
      random_phase(0, 0, 20);

      // output held off while whole frames keep coming, so the input backs up
      hold_req <= !hold_req;
      repeat (2) send_random_frame(1'b0, 1'b1, n);

      settle();
      if (mismatches == 0 && chan_expect_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
